>>> rtl/core/ipid_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the incremental PID core.
// No dependencies; every other file of the block imports this package.
package ipid_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned GAIN_W     = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic signed [DATA_W-1:0] DRIVE_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] DRIVE_MIN = -16'sh7FFF;

  localparam logic signed [DATA_W-1:0] TARGET_RST     = 16'sd400;
  localparam logic signed [GAIN_W-1:0] RISE_NOW_RST   = 32'sd4831209;
  localparam logic signed [GAIN_W-1:0] RISE_BACK1_RST = -32'sd5347737;
  localparam logic signed [GAIN_W-1:0] RISE_BACK2_RST = 32'sd524288;
  localparam logic signed [GAIN_W-1:0] FALL_NOW_RST   = 32'sd5144838;
  localparam logic signed [GAIN_W-1:0] FALL_BACK1_RST = -32'sd6186598;
  localparam logic signed [GAIN_W-1:0] FALL_BACK2_RST = 32'sd1048576;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET     = 8'd0,
    REG_RISING     = 8'd1,
    REG_RISE_NOW   = 8'd2,
    REG_RISE_BACK1 = 8'd3,
    REG_RISE_BACK2 = 8'd4,
    REG_FALL_NOW   = 8'd5,
    REG_FALL_BACK1 = 8'd6,
    REG_FALL_BACK2 = 8'd7
  } ipid_reg_e;

  // Active setpoint and gain set as seen by the datapath.
  typedef struct packed {
    logic signed [DATA_W-1:0] target;
    logic signed [GAIN_W-1:0] gain_now;
    logic signed [GAIN_W-1:0] gain_back1;
    logic signed [GAIN_W-1:0] gain_back2;
    logic                     clear_hist;
  } ipid_cfg_t;

endpackage

>>> rtl/core/ipid_cfg_if.sv
`timescale 1ns / 1ps
// Configuration write channel of the incremental PID core.
// Depends on ipid_pkg for the index and data widths.
interface ipid_cfg_if import ipid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/ipid_meas_if.sv
`timescale 1ns / 1ps
// Measurement input channel of the incremental PID core.
// Depends on ipid_pkg for the sample width.
interface ipid_meas_if import ipid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] measurement;

  modport source (output valid, measurement, input ready);
  modport sink   (input valid, measurement, output ready);
endinterface

>>> rtl/core/ipid_drive_if.sv
`timescale 1ns / 1ps
// Drive output channel of the incremental PID core.
// Depends on ipid_pkg for the sample width.
interface ipid_drive_if import ipid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive_value;

  modport source (output valid, drive_value, input ready);
  modport sink   (input valid, drive_value, output ready);
endinterface

>>> rtl/core/ipid_cfg_regs.sv
`timescale 1ns / 1ps
// Register file of the incremental PID core: setpoint, direction and both gain sets.
// Depends on ipid_pkg and ipid_cfg_if.
module ipid_cfg_regs import ipid_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ipid_cfg_if.sink  cfg_i,
  output ipid_cfg_t cfg_o
);

  logic signed [DATA_W-1:0] target_q;
  logic                     rising_q;
  logic signed [GAIN_W-1:0] rise_now_q, rise_back1_q, rise_back2_q;
  logic signed [GAIN_W-1:0] fall_now_q, fall_back1_q, fall_back2_q;
  logic                     wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= TARGET_RST;
      rising_q     <= 1'b1;
      rise_now_q   <= RISE_NOW_RST;
      rise_back1_q <= RISE_BACK1_RST;
      rise_back2_q <= RISE_BACK2_RST;
      fall_now_q   <= FALL_NOW_RST;
      fall_back1_q <= FALL_BACK1_RST;
      fall_back2_q <= FALL_BACK2_RST;
    end else if (wr_en) begin
      unique case (ipid_reg_e'(cfg_i.index))
        REG_TARGET:     target_q     <= cfg_i.data[DATA_W-1:0];
        REG_RISING:     rising_q     <= cfg_i.data[0];
        REG_RISE_NOW:   rise_now_q   <= cfg_i.data[GAIN_W-1:0];
        REG_RISE_BACK1: rise_back1_q <= cfg_i.data[GAIN_W-1:0];
        REG_RISE_BACK2: rise_back2_q <= cfg_i.data[GAIN_W-1:0];
        REG_FALL_NOW:   fall_now_q   <= cfg_i.data[GAIN_W-1:0];
        REG_FALL_BACK1: fall_back1_q <= cfg_i.data[GAIN_W-1:0];
        REG_FALL_BACK2: fall_back2_q <= cfg_i.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Setpoint and direction writes restart the regulator history.
  always_comb begin
    cfg_o.target     = target_q;
    cfg_o.gain_now   = rising_q ? rise_now_q   : fall_now_q;
    cfg_o.gain_back1 = rising_q ? rise_back1_q : fall_back1_q;
    cfg_o.gain_back2 = rising_q ? rise_back2_q : fall_back2_q;
    cfg_o.clear_hist = wr_en && ((ipid_reg_e'(cfg_i.index) == REG_TARGET) ||
                                 (ipid_reg_e'(cfg_i.index) == REG_RISING));
  end

endmodule

>>> rtl/core/incremental_pid_two_gain_sets_core.sv
`timescale 1ns / 1ps
// Top level of the velocity-form PID regulator with two gain sets.
// Depends on ipid_pkg, the three channel interfaces and ipid_cfg_regs.
//
// Usage:
//   cfg_i   writes one register per transaction (index 0 setpoint, 1 direction,
//           2..4 rising gains, 5..7 falling gains); it is always ready. Indexes
//           above 7 are dropped. Writing the setpoint or the direction clears the
//           error history and the last drive value. Write only while idle.
//   meas_i  takes one measurement per transaction.
//   drive_o returns one saturated drive value per measurement, in order.
// Timing:
//   Three register stages: measurement register, product register, result
//   register. The pipeline takes a new measurement every cycle unless the
//   receiver stalls; the three parallel 16x32 multipliers of the product
//   stage set the clock period. The last drive value feeds back only into
//   the final add and saturate.
// Reset and stall:
//   Reset restores the default setpoint, rising direction and gain sets and
//   empties the pipeline. When the receiver stalls, the result register holds
//   and earlier stages keep filling until each holds an item; then meas_i
//   drops ready. No transaction is lost or repeated.
module incremental_pid_two_gain_sets_core import ipid_pkg::*; #(
  parameter int unsigned FRAC_BITS = 19
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ipid_cfg_if.sink      cfg_i,
  ipid_meas_if.sink     meas_i,
  ipid_drive_if.source  drive_o
);

  localparam int unsigned ProdW = DATA_W + GAIN_W;
  // Three products plus the previous drive need two guard bits.
  localparam int unsigned SumW  = ProdW + 2;

  ipid_cfg_t cfg;

  ipid_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Stage valids and advance enables. Each stage moves when the next one
  // is empty or moving itself.
  logic a_valid_q, b_valid_q, out_valid_q;
  logic en_a, en_b, en_out;

  assign en_out       = !out_valid_q || drive_o.ready;
  assign en_b         = !b_valid_q || en_out;
  assign en_a         = !a_valid_q || en_b;
  assign meas_i.ready = en_a;

  // Stage A: registered measurement.
  logic signed [DATA_W-1:0] meas_q;

  // Error history, e[n-1] and e[n-2], and the previous drive.
  logic signed [DATA_W-1:0] err1_q, err2_q, last_drive_q;

  // Stage B: the three products.
  logic signed [DATA_W-1:0] err_d;
  logic signed [ProdW-1:0]  p_now_d, p_back1_d, p_back2_d;
  logic signed [ProdW-1:0]  p_now_q, p_back1_q, p_back2_q;

  // Output stage: sum, scale, add previous drive, saturate.
  logic signed [SumW-1:0]   sum_d, scaled_d, total_d;
  logic signed [DATA_W-1:0] drive_d, drive_q;

  assign err_d     = DATA_W'(cfg.target - meas_q);
  assign p_now_d   = ProdW'(err_d)  * ProdW'(cfg.gain_now);
  assign p_back1_d = ProdW'(err1_q) * ProdW'(cfg.gain_back1);
  assign p_back2_d = ProdW'(err2_q) * ProdW'(cfg.gain_back2);

  // The previous drive enters the accumulator shifted up by FRAC_BITS, so its
  // low bits are zero and it can be added after the floor shift instead.
  assign sum_d    = SumW'(p_now_q) + SumW'(p_back1_q) + SumW'(p_back2_q);
  assign scaled_d = sum_d >>> FRAC_BITS;
  assign total_d  = scaled_d + SumW'(last_drive_q);

  always_comb begin
    if (total_d > SumW'(DRIVE_MAX)) begin
      drive_d = DRIVE_MAX;
    end else if (total_d < SumW'(DRIVE_MIN)) begin
      drive_d = DRIVE_MIN;
    end else begin
      drive_d = total_d[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_a) begin
        a_valid_q <= meas_i.valid;
      end
      if (en_b) begin
        b_valid_q <= a_valid_q;
      end
      if (en_out) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  // History registers. The user must keep configuration writes to times when the
  // pipeline is empty; the block does not enforce it. A clear wins over an update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err1_q       <= '0;
      err2_q       <= '0;
      last_drive_q <= '0;
    end else if (cfg.clear_hist) begin
      err1_q       <= '0;
      err2_q       <= '0;
      last_drive_q <= '0;
    end else begin
      if (en_b && a_valid_q) begin
        err1_q <= err_d;
        err2_q <= err1_q;
      end
      if (en_out && b_valid_q) begin
        last_drive_q <= drive_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_a && meas_i.valid) begin
      meas_q <= meas_i.measurement;
    end
    if (en_b && a_valid_q) begin
      p_now_q   <= p_now_d;
      p_back1_q <= p_back1_d;
      p_back2_q <= p_back2_d;
    end
    if (en_out && b_valid_q) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o.valid       = out_valid_q;
  assign drive_o.drive_value = drive_q;

  // The saturation never lets the most negative code through.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_o.valid |-> (drive_o.drive_value != -16'sh8000))
    else $error("drive value reached the excluded negative code");

  // The fed-back drive equals the most recently produced result, except in a history clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (drive_o.valid && !cfg.clear_hist) |-> (last_drive_q == drive_q))
    else $error("fed-back drive differs from the last result");

  // A setpoint or direction write leaves the history cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg.clear_hist |=> (err1_q == '0 && err2_q == '0 && last_drive_q == '0))
    else $error("history not cleared after setpoint or direction write");

  // An item held in the product stage is not dropped while the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !en_out) |=> (b_valid_q && $stable(p_now_q)))
    else $error("product stage lost an item during a stall");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for incremental_pid_two_gain_sets_core.
// Depends on ipid_pkg, the three channel interfaces and the core itself.
module tb_top import ipid_pkg::*; ();

  localparam int FRAC = 19;

  // The watchdog gives up after this many cycles without any transaction.
  // The longest legal quiet stretch is the long output stall below.
  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 120;
  localparam int ITEM_TARGET = 600;

  localparam logic signed [DATA_W-1:0] MEAS_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] MEAS_MAX = 16'sh7FFF;

  // Register indexes past the end of the map; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_FIRST = CFG_IDX_W'(REG_FALL_BACK2 + 1);
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_LAST  = '1;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 32'h7FFF_FFFF;
  localparam logic [GAIN_W-1:0] GAIN_MIN = 32'h8000_0000;

  typedef enum int {SINK_ALWAYS, SINK_RANDOM, SINK_PATTERN, SINK_SPARSE} sink_style_e;
  typedef enum int {STYLE_LOOP, STYLE_WIDE, STYLE_MIXED} phase_style_e;

  logic clk_i;
  logic rst_ni;

  ipid_cfg_if   cfg_ch ();
  ipid_meas_if  meas_ch ();
  ipid_drive_if drive_ch ();

  incremental_pid_two_gain_sets_core #(
    .FRAC_BITS (FRAC)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_ch),
    .meas_i  (meas_ch),
    .drive_o (drive_ch)
  );

  // ---------------------------------------------------------------------------
  // Regulator state as the testbench predicts it. Register writes update it
  // when the write transaction is accepted, measurements when theirs is.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] setpoint;
  logic                     use_rise_set;
  logic signed [GAIN_W-1:0] rise_gain [3];  // current, one back, two back
  logic signed [GAIN_W-1:0] fall_gain [3];
  logic signed [DATA_W-1:0] err_back1;
  logic signed [DATA_W-1:0] err_back2;
  logic signed [DATA_W-1:0] drive_prev;

  // Drive values still owed by the block, oldest first.
  logic signed [DATA_W-1:0] expected_drive_q [$];

  int fail_count;
  int meas_sent;
  int drives_checked;
  int phases_run;

  // Sender and receiver idling controls.
  bit          gaps_on;
  int          burst_left;
  sink_style_e sink_style;
  int          hold_requests;

  function automatic void clear_history();
    err_back1  = '0;
    err_back2  = '0;
    drive_prev = '0;
  endfunction

  function automatic void reset_model();
    setpoint     = TARGET_RST;
    use_rise_set = 1'b1;
    rise_gain[0] = RISE_NOW_RST;
    rise_gain[1] = RISE_BACK1_RST;
    rise_gain[2] = RISE_BACK2_RST;
    fall_gain[0] = FALL_NOW_RST;
    fall_gain[1] = FALL_BACK1_RST;
    fall_gain[2] = FALL_BACK2_RST;
    clear_history();
  endfunction

  // Only the setpoint and direction registers restart the regulator; gain
  // writes keep the error history and the last drive value.
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_TARGET: begin
        setpoint = data[DATA_W-1:0];
        clear_history();
      end
      REG_RISING: begin
        use_rise_set = data[0];
        clear_history();
      end
      REG_RISE_NOW:   rise_gain[0] = data;
      REG_RISE_BACK1: rise_gain[1] = data;
      REG_RISE_BACK2: rise_gain[2] = data;
      REG_FALL_NOW:   fall_gain[0] = data;
      REG_FALL_BACK1: fall_gain[1] = data;
      REG_FALL_BACK2: fall_gain[2] = data;
      default: ;
    endcase
  endfunction

  // One control period: wrap the error to 16 bits, form the Q19 sum with the
  // previous drive, floor-shift, clamp symmetrically and advance the history.
  function automatic logic signed [DATA_W-1:0] predict_drive(
      input logic signed [DATA_W-1:0] meas);
    logic signed [DATA_W-1:0] err;
    logic signed [GAIN_W-1:0] g_now, g_b1, g_b2;
    longint                   acc;
    longint                   y;
    err = setpoint - meas;
    if (use_rise_set) begin
      g_now = rise_gain[0];
      g_b1  = rise_gain[1];
      g_b2  = rise_gain[2];
    end else begin
      g_now = fall_gain[0];
      g_b1  = fall_gain[1];
      g_b2  = fall_gain[2];
    end
    acc = longint'(err) * longint'(g_now)
        + longint'(err_back1) * longint'(g_b1)
        + longint'(err_back2) * longint'(g_b2)
        + (longint'(drive_prev) <<< FRAC);
    // Arithmetic shift of a signed value rounds toward minus infinity.
    y = acc >>> FRAC;
    if (y > longint'(DRIVE_MAX)) y = longint'(DRIVE_MAX);
    if (y < longint'(DRIVE_MIN)) y = longint'(DRIVE_MIN);
    err_back2  = err_back1;
    err_back1  = err;
    drive_prev = y[DATA_W-1:0];
    return drive_prev;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Output side. The receiver stalls on its own pattern; a long hold-off is
  // started whenever the stimulus bumps hold_requests, and it is counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_served;
    int hold_left;
    int beat;
    hold_served = 0;
    hold_left   = 0;
    beat        = 0;
    drive_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      beat++;
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        drive_ch.ready <= 1'b0;
      end else begin
        case (sink_style)
          SINK_ALWAYS:  drive_ch.ready <= 1'b1;
          SINK_RANDOM:  drive_ch.ready <= 1'($urandom_range(0, 1));
          SINK_PATTERN: drive_ch.ready <= (beat % 5) >= 2;
          default:      drive_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Every accepted drive value is compared with the oldest prediction. Inputs
  // and outputs are read right after the edge, so they still hold the values
  // that the edge sampled.
  always @(posedge clk_i) begin
    logic signed [DATA_W-1:0] want;
    if (rst_ni && drive_ch.valid && drive_ch.ready) begin
      if (expected_drive_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: drive_value with none pending, expected none, actual %0d",
                 $time, drive_ch.drive_value);
      end else begin
        want = expected_drive_q.pop_front();
        drives_checked++;
        if (drive_ch.drive_value !== want) begin
          fail_count++;
          $display("%0t ns: drive_value mismatch, expected %0d, actual %0d",
                   $time, want, drive_ch.drive_value);
        end
      end
    end
  end

  // Watchdog: a run that stops moving transactions is a failure.
  always @(posedge clk_i) begin
    int quiet_cycles;
    if (!rst_ni || (cfg_ch.valid && cfg_ch.ready) || (meas_ch.valid && meas_ch.ready)
        || (drive_ch.valid && drive_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transaction for %0d cycles, %0d drive values pending",
                 $time, IDLE_LIMIT, expected_drive_q.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks
  // ---------------------------------------------------------------------------

  // Leaves valid high so that back-to-back writes need no second assignment in
  // one time step; close_cfg lowers it once the sequence is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    apply_reg_write(idx, data);
  endtask

  task automatic close_cfg();
    cfg_ch.valid <= 1'b0;
  endtask

  // Offers one measurement and, once the transaction is taken, records the
  // drive value it must produce. With gaps on, the sender works in bursts.
  task automatic send_measurement(input logic signed [DATA_W-1:0] m);
    meas_ch.valid       <= 1'b1;
    meas_ch.measurement <= m;
    do @(posedge clk_i); while (!meas_ch.ready);
    expected_drive_q.push_back(predict_drive(m));
    meas_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        meas_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stops sending and waits until every predicted drive value has arrived.
  // Every measurement yields a drive value, so the block is idle afterwards.
  task automatic wait_for_drives();
    meas_ch.valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] tame_gain();
    int g;
    g = int'($urandom_range(0, 1 << 24)) - (1 << 23);
    return g;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] tame_target();
    int t;
    t = int'($urandom_range(0, 16000)) - 8000;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: rising set, setpoint 400, no register written yet.
  task automatic test_reset_defaults();
    send_measurement(16'sd0);
    send_measurement(16'sd400);
    send_measurement(16'sd380);
    send_measurement(16'sd420);
    wait_for_drives();
  endtask

  // Writes past index 7 must change nothing. Index 8 with zero data would
  // also clear the history if the decode only looked at the low bits.
  task automatic test_unmapped_index();
    write_reg(UNMAPPED_FIRST, '0);
    write_reg(UNMAPPED_LAST, $urandom);
    close_cfg();
    send_measurement(16'sd390);
    send_measurement(16'sd405);
    wait_for_drives();
  endtask

  // Setpoint minus measurement at opposite extremes wraps around 16 bits.
  task automatic test_error_wrap();
    write_reg(REG_TARGET, {16'h0000, MEAS_MAX});
    close_cfg();
    send_measurement(MEAS_MIN);
    send_measurement(MEAS_MAX);
    wait_for_drives();
    write_reg(REG_TARGET, {16'hFFFF, MEAS_MIN});
    close_cfg();
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    wait_for_drives();
  endtask

  // Extreme gains in both sets drive the output into both clamps. The
  // second direction write carries junk in its upper bits; only bit 0 counts.
  task automatic test_saturation();
    write_reg(REG_TARGET, '0);
    write_reg(REG_RISING, 32'h0000_0001);
    write_reg(REG_RISE_NOW, GAIN_MAX);
    write_reg(REG_RISE_BACK1, GAIN_MIN);
    write_reg(REG_RISE_BACK2, GAIN_MAX);
    close_cfg();
    send_measurement(-16'sd1);
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    send_measurement(-16'sd1);
    wait_for_drives();
    write_reg(REG_RISING, 32'hFFFF_FFFE);
    write_reg(REG_FALL_NOW, GAIN_MIN);
    write_reg(REG_FALL_BACK1, GAIN_MAX);
    write_reg(REG_FALL_BACK2, GAIN_MIN);
    close_cfg();
    send_measurement(MEAS_MAX);
    send_measurement(MEAS_MIN);
    send_measurement(16'sd1);
    send_measurement(16'sd0);
    wait_for_drives();
  endtask

  // A gain write in mid-run keeps the history; rewriting the direction with
  // the same value still restarts the regulator.
  task automatic test_history_clear();
    write_reg(REG_FALL_NOW, FALL_NOW_RST);
    write_reg(REG_FALL_BACK1, FALL_BACK1_RST);
    write_reg(REG_FALL_BACK2, FALL_BACK2_RST);
    write_reg(REG_TARGET, CFG_DATA_W'(TARGET_RST));
    close_cfg();
    send_measurement(16'sd300);
    send_measurement(16'sd350);
    wait_for_drives();
    write_reg(REG_FALL_NOW, 32'd2000000);
    close_cfg();
    send_measurement(16'sd380);
    wait_for_drives();
    write_reg(REG_RISING, '0);
    close_cfg();
    send_measurement(16'sd380);
    send_measurement(16'sd390);
    wait_for_drives();
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering, so the pipeline fills and must stall its input. Afterwards the
  // sender pauses until every drive value is back.
  task automatic test_output_stall();
    int plant;
    gaps_on = 1'b0;
    sink_style    <= SINK_ALWAYS;
    hold_requests <= hold_requests + 1;
    plant = int'(setpoint);
    repeat (40) begin
      send_measurement(plant[DATA_W-1:0]);
      plant = plant + ((int'(drive_prev) - plant) >>> 3);
    end
    wait_for_drives();
  endtask

  // Random phases until the item budget is spent. Most phases close the loop
  // through a simple first-order plant with moderate gains, so the
  // measurement follows the drive as it would in service. The rest use full
  // range gains, setpoints and measurements, or add extremes.
  task automatic test_random_phases();
    phase_style_e               style;
    int                         pick;
    int                         plant;
    int                         n_items;
    logic [CFG_IDX_W-1:0]       ri;
    bit [31:0]                  r;
    logic signed [DATA_W-1:0]   m;
    while (meas_sent < ITEM_TARGET) begin
      wait_for_drives();
      pick  = $urandom_range(0, 9);
      style = (pick < 6) ? STYLE_LOOP : (pick < 8) ? STYLE_WIDE : STYLE_MIXED;

      if ($urandom_range(0, 9) < 7) begin
        write_reg(REG_TARGET, (style == STYLE_LOOP) ? tame_target() : $urandom);
        write_reg(REG_RISING, $urandom);
      end
      for (ri = REG_RISE_NOW; ri <= REG_FALL_BACK2; ri++) begin
        if ($urandom_range(0, 3) != 0)
          write_reg(ri, (style == STYLE_WIDE) ? $urandom : tame_gain());
      end
      close_cfg();

      gaps_on    = ($urandom_range(0, 2) != 0);
      sink_style <= sink_style_e'($urandom_range(0, 3));
      phases_run++;

      n_items = $urandom_range(30, 70);
      plant   = int'(setpoint) + int'($urandom_range(0, 1200)) - 600;
      repeat (n_items) begin
        r = $urandom;
        case (style)
          STYLE_LOOP: begin
            if (plant > int'(MEAS_MAX)) plant = int'(MEAS_MAX);
            if (plant < int'(MEAS_MIN)) plant = int'(MEAS_MIN);
            m = plant[DATA_W-1:0];
          end
          STYLE_WIDE: m = r[DATA_W-1:0];
          default: begin
            if (r[31:29] == 3'b000)
              m = r[28] ? MEAS_MAX : MEAS_MIN;
            else
              m = r[DATA_W-1:0];
          end
        endcase
        send_measurement(m);
        plant = plant + ((int'(drive_prev) - plant) >>> 2)
              + int'($urandom_range(0, 6)) - 3;
      end
    end
    wait_for_drives();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count     = 0;
    meas_sent      = 0;
    drives_checked = 0;
    phases_run     = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    sink_style     <= SINK_RANDOM;
    hold_requests  <= 0;

    rst_ni              <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= REG_TARGET;
    cfg_ch.data         <= '0;
    meas_ch.valid       <= 1'b0;
    meas_ch.measurement <= '0;
    reset_model();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_unmapped_index();
    test_error_wrap();
    test_saturation();
    test_history_clear();
    test_output_stall();
    test_random_phases();

    // Let a few more cycles pass so that a stray extra result is caught.
    repeat (8) @(posedge clk_i);

    $display("Ran %0d measurements, %0d random configuration phases, %0d drive values checked.",
             meas_sent, phases_run, drives_checked);
    $display("Covered both gain sets, error wrap, both clamps, history restarts, %s",
             "unmapped writes and a long output stall.");
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
